// File: rtl/assert_macros.svh
// shared concurrent assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/l2mi_pkg.sv
package l2mi_pkg;

   localparam int MAX_DIMS_DEFAULT     = 4;
   localparam int INDEX_WIDTH_DEFAULT  = 32;
   localparam int EXTENT_WIDTH_DEFAULT = 16;

   localparam int COORD_COUNT    = 4;
   localparam int DIM_SEL_WIDTH  = 2;
   localparam int DIM_CNT_WIDTH  = 3;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [2:0] REG_DIM_COUNT    = 3'd0;
   localparam logic [2:0] REG_LAYOUT_ORDER = 3'd1;
   localparam logic [2:0] REG_EXTENT_DIM0  = 3'd2;
   localparam logic [2:0] REG_EXTENT_DIM1  = 3'd3;
   localparam logic [2:0] REG_EXTENT_DIM2  = 3'd4;
   localparam logic [2:0] REG_EXTENT_DIM3  = 3'd5;

   localparam logic LAYOUT_ROW_MAJOR = 1'b0;

endpackage

// File: rtl/l2mi_divider.sv
`include "assert_macros.svh"

module l2mi_divider import l2mi_pkg::*; #(
   parameter int INDEX_WIDTH  = INDEX_WIDTH_DEFAULT,
   parameter int EXTENT_WIDTH = EXTENT_WIDTH_DEFAULT,
   parameter int SIDE_WIDTH   = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  logic [INDEX_WIDTH-1:0]  in_num,
   input  logic [EXTENT_WIDTH-1:0] in_div,
   input  logic [SIDE_WIDTH-1:0]   in_side,
   output logic                    out_valid,
   output logic [INDEX_WIDTH-1:0]  out_quot,
   output logic [EXTENT_WIDTH-1:0] out_rem,
   output logic [SIDE_WIDTH-1:0]   out_side
);

   logic                    valid_ff [INDEX_WIDTH];
   logic [INDEX_WIDTH-1:0]  num_ff   [INDEX_WIDTH];
   logic [EXTENT_WIDTH-1:0] rem_ff   [INDEX_WIDTH];
   logic [EXTENT_WIDTH-1:0] div_ff   [INDEX_WIDTH];
   logic [SIDE_WIDTH-1:0]   side_ff  [INDEX_WIDTH];

   for (genvar s = 0; s < INDEX_WIDTH; s++) begin : g_stage
      logic                    prev_valid;
      logic [INDEX_WIDTH-1:0]  prev_num;
      logic [EXTENT_WIDTH-1:0] prev_rem;
      logic [EXTENT_WIDTH-1:0] prev_div;
      logic [SIDE_WIDTH-1:0]   prev_side;
      logic [EXTENT_WIDTH:0]   trial;
      logic                    fits;
      logic [EXTENT_WIDTH:0]   diff;
      logic [INDEX_WIDTH-1:0]  num_in;
      logic [EXTENT_WIDTH-1:0] rem_in;

      if (s == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_num   = in_num;
         assign prev_rem   = '0;
         assign prev_div   = in_div;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[s-1];
         assign prev_num   = num_ff[s-1];
         assign prev_rem   = rem_ff[s-1];
         assign prev_div   = div_ff[s-1];
         assign prev_side  = side_ff[s-1];
      end

      always_comb begin
         trial  = {prev_rem, prev_num[INDEX_WIDTH-1]};
         fits   = trial >= {1'b0, prev_div};
         diff   = trial - {1'b0, prev_div};
         rem_in = fits ? diff[EXTENT_WIDTH-1:0] : trial[EXTENT_WIDTH-1:0];
         num_in = {prev_num[INDEX_WIDTH-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= prev_valid;
         end
         if (enable) begin
            num_ff[s]  <= num_in;
            rem_ff[s]  <= rem_in;
            div_ff[s]  <= prev_div;
            side_ff[s] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[INDEX_WIDTH-1];
   assign out_quot  = num_ff[INDEX_WIDTH-1];
   assign out_rem   = rem_ff[INDEX_WIDTH-1];
   assign out_side  = side_ff[INDEX_WIDTH-1];

   `ASSERT_IMPLIES(a_rem_below_div, clock, reset,
      out_valid && (div_ff[INDEX_WIDTH-1] != '0), out_rem < div_ff[INDEX_WIDTH-1],
      "remainder not below divisor")
   `ASSERT_NEXT(a_hold_when_off, clock, reset, !enable && out_valid,
      out_valid && $stable(out_quot) && $stable(out_rem), "divider moved while held")

endmodule

// File: rtl/linear_to_multi_index.sv
// channel  direction  ports
// req      in         req_valid, req_stall, req_linear_index
// rsp      out        rsp_valid, rsp_stall, rsp_coord_dim0..3, flags
// csr      in/out     csr_psel, csr_penable, csr_pwrite, csr_paddr, ...
// one item enters per cycle while req_stall is low; each dimension slot is a
// divider pipeline that resolves one quotient bit per stage
// synchronous reset clears valid bits and dim count; order row-major, extents 1
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
`include "assert_macros.svh"

module linear_to_multi_index import l2mi_pkg::*; #(
   parameter int MAX_DIMS     = MAX_DIMS_DEFAULT,
   parameter int INDEX_WIDTH  = INDEX_WIDTH_DEFAULT,
   parameter int EXTENT_WIDTH = EXTENT_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [INDEX_WIDTH-1:0]    req_linear_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [EXTENT_WIDTH-1:0]   rsp_coord_dim0,
   output logic [EXTENT_WIDTH-1:0]   rsp_coord_dim1,
   output logic [EXTENT_WIDTH-1:0]   rsp_coord_dim2,
   output logic [EXTENT_WIDTH-1:0]   rsp_coord_dim3,
   output logic                      rsp_zero_extent_error,
   output logic                      rsp_out_of_range,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   localparam int SLOTS     = (MAX_DIMS < COORD_COUNT) ? MAX_DIMS : COORD_COUNT;
   localparam int COORD_OFF = 0;
   localparam int DIV_OFF   = COORD_OFF + COORD_COUNT * EXTENT_WIDTH;
   localparam int DIM_OFF   = DIV_OFF + SLOTS * EXTENT_WIDTH;
   localparam int ACT_OFF   = DIM_OFF + SLOTS * DIM_SEL_WIDTH;
   localparam int ZERO_OFF  = ACT_OFF + SLOTS;
   localparam int SW        = ZERO_OFF + 1;

   logic [DIM_CNT_WIDTH-1:0] dim_count_ff;
   logic                     layout_order_ff;
   logic [EXTENT_WIDTH-1:0]  extent_ff [COORD_COUNT];

   logic                     csr_write;
   logic [2:0]               csr_reg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = csr_paddr[CSR_ADDR_WIDTH-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff    <= '0;
         layout_order_ff <= LAYOUT_ROW_MAJOR;
         for (int i = 0; i < COORD_COUNT; i++) begin
            extent_ff[i] <= EXTENT_WIDTH'(1);
         end
      end else if (csr_write) begin
         unique case (csr_reg)
            REG_DIM_COUNT:    dim_count_ff    <= csr_pwdata[DIM_CNT_WIDTH-1:0];
            REG_LAYOUT_ORDER: layout_order_ff <= csr_pwdata[0];
            REG_EXTENT_DIM0:  extent_ff[0]    <= csr_pwdata[EXTENT_WIDTH-1:0];
            REG_EXTENT_DIM1:  extent_ff[1]    <= csr_pwdata[EXTENT_WIDTH-1:0];
            REG_EXTENT_DIM2:  extent_ff[2]    <= csr_pwdata[EXTENT_WIDTH-1:0];
            REG_EXTENT_DIM3:  extent_ff[3]    <= csr_pwdata[EXTENT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_reg)
         REG_DIM_COUNT:    csr_prdata = CSR_DATA_WIDTH'(dim_count_ff);
         REG_LAYOUT_ORDER: csr_prdata = CSR_DATA_WIDTH'(layout_order_ff);
         REG_EXTENT_DIM0:  csr_prdata = CSR_DATA_WIDTH'(extent_ff[0]);
         REG_EXTENT_DIM1:  csr_prdata = CSR_DATA_WIDTH'(extent_ff[1]);
         REG_EXTENT_DIM2:  csr_prdata = CSR_DATA_WIDTH'(extent_ff[2]);
         REG_EXTENT_DIM3:  csr_prdata = CSR_DATA_WIDTH'(extent_ff[3]);
         default:          csr_prdata = '0;
      endcase
   end

   // slot setup from configuration
   logic                     advance;
   logic [DIM_CNT_WIDTH-1:0] n_eff;
   logic [DIM_CNT_WIDTH-1:0] dest;
   logic                     zero_ext;
   logic [SW-1:0]            entry_side;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      n_eff = (dim_count_ff > DIM_CNT_WIDTH'(SLOTS)) ? DIM_CNT_WIDTH'(SLOTS) : dim_count_ff;
      zero_ext   = 1'b0;
      entry_side = '0;
      dest       = '0;
      for (int k = 0; k < SLOTS; k++) begin
         if (DIM_CNT_WIDTH'(k) < n_eff && extent_ff[k] == '0) begin
            zero_ext = 1'b1;
         end
      end
      for (int k = 0; k < SLOTS; k++) begin
         dest = (layout_order_ff == LAYOUT_ROW_MAJOR) ?
                n_eff - DIM_CNT_WIDTH'(1) - DIM_CNT_WIDTH'(k) : DIM_CNT_WIDTH'(k);
         if (DIM_CNT_WIDTH'(k) < n_eff) begin
            entry_side[ACT_OFF + k] = 1'b1;
            entry_side[DIM_OFF + k*DIM_SEL_WIDTH +: DIM_SEL_WIDTH] = dest[DIM_SEL_WIDTH-1:0];
            entry_side[DIV_OFF + k*EXTENT_WIDTH +: EXTENT_WIDTH] =
               extent_ff[dest[DIM_SEL_WIDTH-1:0]];
         end else begin
            entry_side[DIV_OFF + k*EXTENT_WIDTH +: EXTENT_WIDTH] = EXTENT_WIDTH'(1);
         end
      end
      entry_side[ZERO_OFF] = zero_ext;
   end

   logic                    slot_valid [SLOTS];
   logic [INDEX_WIDTH-1:0]  slot_quot  [SLOTS];
   logic [EXTENT_WIDTH-1:0] slot_rem   [SLOTS];
   logic [SW-1:0]           slot_side  [SLOTS];
   logic [SW-1:0]           post_side  [SLOTS];

   for (genvar k = 0; k < SLOTS; k++) begin : g_slot
      logic                    in_valid;
      logic [INDEX_WIDTH-1:0]  in_num;
      logic [SW-1:0]           in_side;
      logic [DIM_SEL_WIDTH-1:0] dim_sel;

      if (k == 0) begin : g_head
         assign in_valid = req_valid;
         assign in_num   = req_linear_index;
         assign in_side  = entry_side;
      end else begin : g_chain
         assign in_valid = slot_valid[k-1];
         assign in_num   = slot_quot[k-1];
         assign in_side  = post_side[k-1];
      end

      l2mi_divider #(
         .INDEX_WIDTH  (INDEX_WIDTH),
         .EXTENT_WIDTH (EXTENT_WIDTH),
         .SIDE_WIDTH   (SW)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (in_valid),
         .in_num    (in_num),
         .in_div    (in_side[DIV_OFF + k*EXTENT_WIDTH +: EXTENT_WIDTH]),
         .in_side   (in_side),
         .out_valid (slot_valid[k]),
         .out_quot  (slot_quot[k]),
         .out_rem   (slot_rem[k]),
         .out_side  (slot_side[k])
      );

      assign dim_sel = slot_side[k][DIM_OFF + k*DIM_SEL_WIDTH +: DIM_SEL_WIDTH];

      always_comb begin
         post_side[k] = slot_side[k];
         if (slot_side[k][ACT_OFF + k]) begin
            post_side[k][COORD_OFF + dim_sel*EXTENT_WIDTH +: EXTENT_WIDTH] = slot_rem[k];
         end
      end
   end

   logic [SW-1:0] final_side;
   logic          final_zero;

   assign final_side = post_side[SLOTS-1];
   assign final_zero = final_side[ZERO_OFF];

   assign rsp_valid             = slot_valid[SLOTS-1];
   assign rsp_zero_extent_error = final_zero;
   assign rsp_out_of_range      = !final_zero && (slot_quot[SLOTS-1] != '0);
   assign rsp_coord_dim0 = final_zero ? '0 : final_side[COORD_OFF +: EXTENT_WIDTH];
   assign rsp_coord_dim1 = final_zero ? '0 : final_side[COORD_OFF + EXTENT_WIDTH +: EXTENT_WIDTH];
   assign rsp_coord_dim2 = final_zero ? '0 :
                           final_side[COORD_OFF + 2*EXTENT_WIDTH +: EXTENT_WIDTH];
   assign rsp_coord_dim3 = final_zero ? '0 :
                           final_side[COORD_OFF + 3*EXTENT_WIDTH +: EXTENT_WIDTH];

   `ASSERT_IMPLIES(a_zero_ext_clean, clock, reset, rsp_valid && rsp_zero_extent_error,
      !rsp_out_of_range && rsp_coord_dim0 == '0 && rsp_coord_dim3 == '0,
      "zero extent result not cleared")
   `ASSERT_IMPLIES(a_stall_backs_up, clock, reset, rsp_valid && rsp_stall, req_stall,
      "input taken while output stalled")

endmodule

// File: verif/linear_to_multi_index_checker.sv
module linear_to_multi_index_checker import l2mi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_linear_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_coord_dim0,
   input  logic [15:0] rsp_coord_dim1,
   input  logic [15:0] rsp_coord_dim2,
   input  logic [15:0] rsp_coord_dim3,
   input  logic        rsp_zero_extent_error,
   input  logic        rsp_out_of_range,
   input  logic [2:0]  dim_count,
   input  logic        layout_order,
   input  logic [15:0] extent [4],
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] c0, c1, c2, c3;
      logic        zext;
      logic        oor;
   } coords_type;

   coords_type coords_q [$];

   function automatic coords_type unravel(logic [31:0] idx);
      coords_type r;
      logic [15:0] c [4];
      logic [31:0] rest;
      int n, d;
      bit zext;
      rest = idx;
      n = (dim_count > 4) ? 4 : dim_count;
      zext = 0;
      for (int k = 0; k < 4; k++) c[k] = '0;
      for (int k = 0; k < n; k++) if (extent[k] == 0) zext = 1;
      if (!zext) begin
         for (int k = 0; k < n; k++) begin
            d = (layout_order != LAYOUT_ROW_MAJOR) ? k : n - 1 - k;
            c[d] = 16'(rest % extent[d]);
            rest = rest / extent[d];
         end
      end
      r.c0 = c[0]; r.c1 = c[1]; r.c2 = c[2]; r.c3 = c[3];
      r.zext = zext;
      r.oor = !zext && rest != 0;
      return r;
   endfunction

   assign pending = coords_q.size();

   always @(posedge clock) begin
      coords_type e, a;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) coords_q.push_back(unravel(req_linear_index));
         if (rsp_valid && !rsp_stall) begin
            a = {rsp_coord_dim0, rsp_coord_dim1, rsp_coord_dim2, rsp_coord_dim3,
                 rsp_zero_extent_error, rsp_out_of_range};
            if (coords_q.size() == 0) begin
               $display("%0t: unexpected item, actual %h", $time, a);
               fail_count <= fail_count + 1;
            end else begin
               e = coords_q.pop_front();
               if (e !== a) begin
                  $display("%0t: expected %h actual %h", $time, e, a);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: verif/linear_to_multi_index_test.sv
module linear_to_multi_index_test import l2mi_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 4 * 32;
   localparam int LIMIT = 20000;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0;
   logic [31:0] req_linear_index = 0;
   logic req_stall, rsp_valid, rsp_zero_extent_error, rsp_out_of_range, csr_pready;
   logic [15:0] rsp_coord_dim0, rsp_coord_dim1, rsp_coord_dim2, rsp_coord_dim3;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = 0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = 0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic [2:0] dim_count = 0;
   logic layout_order = 0;
   logic [15:0] extent [4] = '{1, 1, 1, 1};
   int fail_count, pending, idle_cycles = 0;
   bit rsp_random = 0, rsp_hold = 0;

   always #5 clock = ~clock;

   linear_to_multi_index uut (.*);

   linear_to_multi_index_checker chk (.*);

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver side stalling
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            rsp_hold = 0;
            rsp_stall <= 0;
         end else if (rsp_random && $urandom_range(3) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 9) - 1) @(posedge clock);
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   task automatic write_reg(logic [2:0] r, logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= CSR_ADDR_WIDTH'(r) << 2; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (r)
         REG_DIM_COUNT:    dim_count = v[2:0];
         REG_LAYOUT_ORDER: layout_order = v[0];
         default:          extent[r - REG_EXTENT_DIM0] = v[15:0];
      endcase
   endtask

   task automatic send_index(logic [31:0] idx, bit gaps);
      if (gaps && $urandom_range(4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1;
      req_linear_index <= idx;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_index(int n);
      logic [63:0] prod;
      prod = 1;
      for (int k = 0; k < n; k++) prod = prod * extent[k];
      if ($urandom_range(9) < 7 && prod != 0 && prod <= 64'hFFFF_FFFF)
         return 32'($urandom % prod);
      return $urandom;
   endfunction

   task automatic program_shape(int n, bit order, int maxext);
      write_reg(REG_DIM_COUNT, n);
      write_reg(REG_LAYOUT_ORDER, order);
      for (int k = 0; k < 4; k++)
         write_reg(3'(REG_EXTENT_DIM0 + k), $urandom_range(maxext));
   endtask

   initial begin
      int n;
      repeat (11) @(posedge clock);
      reset <= 0;
      // no dimensions: only zero is in range
      send_index(0, 0);
      send_index(1, 0);
      send_index(32'hFFFF_FFFF, 0);
      drain();
      write_reg(REG_DIM_COUNT, 4);
      write_reg(REG_LAYOUT_ORDER, 0);
      for (int k = 0; k < 4; k++) write_reg(3'(REG_EXTENT_DIM0 + k), 16'hFFFF);
      send_index(0, 0);
      send_index(32'hFFFF_FFFF, 0);
      send_index(32'h1234_5678, 0);
      drain();
      write_reg(REG_LAYOUT_ORDER, 1);
      write_reg(REG_EXTENT_DIM1, 7);
      send_index(32'hFFFF_FFFF, 0);
      send_index(32'hAAAA_5555, 0);
      drain();
      // zero extent in use, then not in use
      write_reg(REG_EXTENT_DIM2, 0);
      send_index(32'd12345, 0);
      drain();
      write_reg(REG_DIM_COUNT, 2);
      send_index(32'd12345, 0);
      send_index(32'd1_000_000, 0);
      drain();
      // dimension count above four
      write_reg(REG_DIM_COUNT, 7);
      send_index(32'd99, 0);
      drain();
      write_reg(REG_EXTENT_DIM2, 1);
      write_reg(REG_DIM_COUNT, 1);
      write_reg(REG_EXTENT_DIM0, 1);
      send_index(32'd5, 0);
      send_index(32'd0, 0);
      drain();

      // long receiver hold while items keep coming
      program_shape(3, 0, 40);
      rsp_hold = 1;
      for (int i = 0; i < 300; i++) send_index(rand_index(3), 0);
      drain();

      rsp_random = 1;
      for (int ph = 0; ph < 12; ph++) begin
         n = $urandom_range(7);
         program_shape(n, $urandom_range(1),
                       (ph % 3 == 0) ? 65535 : ((ph % 3 == 1) ? 12 : 300));
         if ($urandom_range(3) != 0)
            for (int k = 0; k < 4; k++)
               if (extent[k] == 0) write_reg(3'(REG_EXTENT_DIM0 + k), 1 + $urandom_range(20));
         for (int i = 0; i < 110; i++) send_index(rand_index(n > 4 ? 4 : n), 1);
         drain();
      end

      // last part without idling
      rsp_random = 0;
      program_shape(4, 1, 16);
      for (int i = 0; i < 200; i++) send_index(rand_index(4), 0);
      drain();

      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule

// File: linear_to_multi_index.f
+incdir+rtl
rtl/l2mi_pkg.sv
rtl/l2mi_divider.sv
rtl/linear_to_multi_index.sv
verif/linear_to_multi_index_checker.sv
verif/linear_to_multi_index_test.sv
